[rtl/bpuv_pkg.sv]
// shared constants, codes and types of the box projection uv generator
package bpuv_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int RATIO_BITS = 16;
	localparam int NRM_BITS   = 16;
	localparam int SCALE_BITS = 16;
	localparam int UV_BITS    = 24;
	localparam int CMD_BITS   = 2;
	localparam int FACE_BITS  = 3;
	localparam int STAT_BITS  = 2;
	localparam int REG_BITS   = 2;

	// divider step counter holds the step count itself
	localparam int CNT_BITS   = $clog2(RATIO_BITS + 1);
	// ratio (with the exact one) times scale, and that product after the Q shift
	localparam int MUL_BITS   = RATIO_BITS + 1 + SCALE_BITS;
	localparam int SHIFT_BITS = MUL_BITS - (RATIO_BITS - 8);

	localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(256);

	// commands
	localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ADD     = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_PROJECT = 2'd2;

	// faces
	localparam logic [FACE_BITS-1:0] FACE_PX = 3'd0;
	localparam logic [FACE_BITS-1:0] FACE_NX = 3'd1;
	localparam logic [FACE_BITS-1:0] FACE_PY = 3'd2;
	localparam logic [FACE_BITS-1:0] FACE_NY = 3'd3;
	localparam logic [FACE_BITS-1:0] FACE_PZ = 3'd4;
	localparam logic [FACE_BITS-1:0] FACE_NZ = 3'd5;

	// status codes
	localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_ZERO  = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;

	// register indexes
	localparam logic [REG_BITS-1:0] REG_SCALE_X = 2'd0;
	localparam logic [REG_BITS-1:0] REG_SCALE_Y = 2'd1;
	localparam logic [REG_BITS-1:0] REG_SCALE_Z = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [NRM_BITS-1:0]   nrm_t;

	// bounding box as seen by the projection side
	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
		logic   empty;
	} bounds_t;

	// one projection lane's result
	typedef struct packed {
		logic               done;
		logic               zero;
		logic [UV_BITS-1:0] coord;
	} lane_res_t;

endpackage

[rtl/bpuv_ifs.sv]
// valid/ready channel interfaces for vertex words and uv words
interface bpuv_in_if;
	logic                          valid;
	logic                          ready;
	logic [bpuv_pkg::CMD_BITS-1:0] command;
	bpuv_pkg::coord_t              pos_x;
	bpuv_pkg::coord_t              pos_y;
	bpuv_pkg::coord_t              pos_z;
	bpuv_pkg::nrm_t                nrm_x;
	bpuv_pkg::nrm_t                nrm_y;
	bpuv_pkg::nrm_t                nrm_z;

	modport source (output valid, command, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
		input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
		output ready);
endinterface

interface bpuv_out_if;
	logic                           valid;
	logic                           ready;
	logic [bpuv_pkg::UV_BITS-1:0]   tex_u;
	logic [bpuv_pkg::UV_BITS-1:0]   tex_v;
	logic [bpuv_pkg::FACE_BITS-1:0] face;
	logic [bpuv_pkg::STAT_BITS-1:0] status;

	modport source (output valid, tex_u, tex_v, face, status, input ready);
	modport sink (input valid, tex_u, tex_v, face, status, output ready);
endinterface

[rtl/box_projection_uv_generator.sv]
// top level of the box projection uv generator
// Keeps a bounding box of vertex positions and turns project words into cube-face
// UV coordinates. Clear and add words are taken while the block is idle and give
// no result. A project word occupies the block from its acceptance to the next
// acceptance: its face is picked and registered, the axes are picked, the two
// bit-serial restoring dividers run side by side at one quotient bit per cycle,
// the scale multiply follows, and the output register is loaded once it is free.
// A finished UV word sits in the output register, so the next word may enter while
// it waits to be taken. Scale registers 0 to 2 (x, y, z, unsigned Q8.8) reset to
// 1.0 and are written through cfg_we, cfg_index and cfg_wdata; the user must write
// them only while the block is idle, as the block itself does not enforce it.
module box_projection_uv_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bpuv_pkg::REG_BITS-1:0]   cfg_index,
	input  logic [bpuv_pkg::SCALE_BITS-1:0] cfg_wdata,
	bpuv_in_if.sink                         vtx,
	bpuv_out_if.source                      uv
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEL  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]                       state_q;
	logic [bpuv_pkg::SCALE_BITS-1:0]  scale_x_q, scale_y_q, scale_z_q;
	bpuv_pkg::coord_t                 pos_x_q, pos_y_q, pos_z_q;
	logic [bpuv_pkg::FACE_BITS-1:0]   face_q;
	logic                             out_vld_q;
	logic [bpuv_pkg::UV_BITS-1:0]     tex_u_q, tex_v_q;
	logic [bpuv_pkg::FACE_BITS-1:0]   out_face_q;
	logic [bpuv_pkg::STAT_BITS-1:0]   status_q;

	logic                             acc;
	logic                             do_clr, do_add, do_proj;
	logic [bpuv_pkg::FACE_BITS-1:0]   face_c;
	bpuv_pkg::bounds_t                bounds;
	bpuv_pkg::lane_res_t              lane_u, lane_v;
	bpuv_pkg::coord_t                 pu, lou, hiu, pv, lov, hiv;
	logic [bpuv_pkg::SCALE_BITS-1:0]  scu, scv;
	logic                             lane_start;
	logic                             load_out;

	// word acceptance
	assign vtx.ready = state_q == ST_IDLE;
	assign acc       = vtx.valid && vtx.ready;
	assign do_clr    = acc && vtx.command == bpuv_pkg::CMD_CLEAR;
	assign do_add    = acc && vtx.command == bpuv_pkg::CMD_ADD;
	assign do_proj   = acc && vtx.command == bpuv_pkg::CMD_PROJECT;

	// scale registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= bpuv_pkg::SCALE_RESET;
			scale_y_q <= bpuv_pkg::SCALE_RESET;
			scale_z_q <= bpuv_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bpuv_pkg::REG_SCALE_X: scale_x_q <= cfg_wdata;
				bpuv_pkg::REG_SCALE_Y: scale_y_q <= cfg_wdata;
				bpuv_pkg::REG_SCALE_Z: scale_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bpuv_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (do_clr),
		.add    (do_add),
		.pos_x  (vtx.pos_x),
		.pos_y  (vtx.pos_y),
		.pos_z  (vtx.pos_z),
		.bounds (bounds)
	);

	bpuv_classify u_classify (
		.nrm_x (vtx.nrm_x),
		.nrm_y (vtx.nrm_y),
		.nrm_z (vtx.nrm_z),
		.face  (face_c)
	);

	// project word capture
	always_ff @(posedge clk) begin
		if (do_proj) begin
			pos_x_q <= vtx.pos_x;
			pos_y_q <= vtx.pos_y;
			pos_z_q <= vtx.pos_z;
			face_q  <= face_c;
		end
	end

	// axis pair for the chosen face
	always_comb begin
		if (face_q inside {bpuv_pkg::FACE_PX, bpuv_pkg::FACE_NX}) begin
			pu = pos_y_q; lou = bounds.min_y; hiu = bounds.max_y; scu = scale_y_q;
			pv = pos_z_q; lov = bounds.min_z; hiv = bounds.max_z; scv = scale_z_q;
		end else if (face_q inside {bpuv_pkg::FACE_PY, bpuv_pkg::FACE_NY}) begin
			pu = pos_x_q; lou = bounds.min_x; hiu = bounds.max_x; scu = scale_x_q;
			pv = pos_z_q; lov = bounds.min_z; hiv = bounds.max_z; scv = scale_z_q;
		end else begin
			pu = pos_x_q; lou = bounds.min_x; hiu = bounds.max_x; scu = scale_x_q;
			pv = pos_y_q; lov = bounds.min_y; hiv = bounds.max_y; scv = scale_y_q;
		end
	end

	assign lane_start = state_q == ST_SEL;

	bpuv_lane u_lane_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.p      (pu),
		.lo     (lou),
		.hi     (hiu),
		.scale  (scu),
		.res    (lane_u)
	);

	bpuv_lane u_lane_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.p      (pv),
		.lo     (lov),
		.hi     (hiv),
		.scale  (scv),
		.res    (lane_v)
	);

	assign load_out = state_q == ST_RUN && lane_u.done && lane_v.done
		&& (!out_vld_q || uv.ready);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (do_proj) state_q <= ST_SEL;
				ST_SEL:  state_q <= ST_RUN;
				ST_RUN:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (load_out)
			out_vld_q <= 1'b1;
		else if (uv.ready)
			out_vld_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_face_q <= face_q;
			if (bounds.empty) begin
				tex_u_q  <= '0;
				tex_v_q  <= '0;
				status_q <= bpuv_pkg::STAT_EMPTY;
			end else begin
				tex_u_q  <= lane_u.coord;
				tex_v_q  <= lane_v.coord;
				status_q <= (lane_u.zero || lane_v.zero) ? bpuv_pkg::STAT_ZERO
					: bpuv_pkg::STAT_OK;
			end
		end
	end

	assign uv.valid  = out_vld_q;
	assign uv.tex_u  = tex_u_q;
	assign uv.tex_v  = tex_v_q;
	assign uv.face   = out_face_q;
	assign uv.status = status_q;

`ifndef SYNTHESIS
	// both lanes run the same number of steps
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_u.done == lane_v.done)
		else $error("uv lanes out of step");

	// a lane start drops the previous done
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |=> !lane_u.done && !lane_v.done)
		else $error("lane done not cleared by start");

	// an accepted project word moves to axis selection
	a_proj_seq: assert property (@(posedge clk) disable iff (!arst_n)
		do_proj |=> state_q == ST_SEL)
		else $error("project word not sequenced");

	// an empty box gives zero coordinates
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && status_q == bpuv_pkg::STAT_EMPTY |-> tex_u_q == '0 && tex_v_q == '0)
		else $error("empty box gave nonzero uv");
`endif
endmodule

[rtl/bpuv_bounds.sv]
// running axis-aligned bounding box of vertex positions
module bpuv_bounds (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              add,
	input  bpuv_pkg::coord_t  pos_x,
	input  bpuv_pkg::coord_t  pos_y,
	input  bpuv_pkg::coord_t  pos_z,
	output bpuv_pkg::bounds_t bounds
);
	bpuv_pkg::coord_t min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
	logic             empty_q;

	// clear empties the box, the first add loads it, later adds grow it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
			empty_q <= 1'b1;
		end else if (clr) begin
			min_x_q <= '0;
			min_y_q <= '0;
			min_z_q <= '0;
			max_x_q <= '0;
			max_y_q <= '0;
			max_z_q <= '0;
			empty_q <= 1'b1;
		end else if (add) begin
			empty_q <= 1'b0;
			if (empty_q || pos_x < min_x_q) min_x_q <= pos_x;
			if (empty_q || pos_y < min_y_q) min_y_q <= pos_y;
			if (empty_q || pos_z < min_z_q) min_z_q <= pos_z;
			if (empty_q || pos_x > max_x_q) max_x_q <= pos_x;
			if (empty_q || pos_y > max_y_q) max_y_q <= pos_y;
			if (empty_q || pos_z > max_z_q) max_z_q <= pos_z;
		end
	end

	assign bounds.min_x = min_x_q;
	assign bounds.min_y = min_y_q;
	assign bounds.min_z = min_z_q;
	assign bounds.max_x = max_x_q;
	assign bounds.max_y = max_y_q;
	assign bounds.max_z = max_z_q;
	assign bounds.empty = empty_q;
endmodule

[rtl/bpuv_classify.sv]
// cube face pick from a normal by sign and magnitude compares
module bpuv_classify (
	input  bpuv_pkg::nrm_t                 nrm_x,
	input  bpuv_pkg::nrm_t                 nrm_y,
	input  bpuv_pkg::nrm_t                 nrm_z,
	output logic [bpuv_pkg::FACE_BITS-1:0] face
);
	logic [bpuv_pkg::NRM_BITS:0] ax, ay, az;
	logic                        nx, ny, nz;

	// magnitudes one bit wider so the most negative value fits
	assign nx = nrm_x[bpuv_pkg::NRM_BITS-1];
	assign ny = nrm_y[bpuv_pkg::NRM_BITS-1];
	assign nz = nrm_z[bpuv_pkg::NRM_BITS-1];
	assign ax = nx ? (bpuv_pkg::NRM_BITS+1)'(-$signed({nrm_x[bpuv_pkg::NRM_BITS-1], nrm_x}))
		: {1'b0, nrm_x};
	assign ay = ny ? (bpuv_pkg::NRM_BITS+1)'(-$signed({nrm_y[bpuv_pkg::NRM_BITS-1], nrm_y}))
		: {1'b0, nrm_y};
	assign az = nz ? (bpuv_pkg::NRM_BITS+1)'(-$signed({nrm_z[bpuv_pkg::NRM_BITS-1], nrm_z}))
		: {1'b0, nrm_z};

	// the largest magnitude picks the axis and its sign the face; ties go to the earlier face
	always_comb begin
		if (!nx && ax >= ay && ax >= az)
			face = bpuv_pkg::FACE_PX;
		else if (nx && ay <= ax && az <= ax)
			face = bpuv_pkg::FACE_NX;
		else if (!ny && ay >= ax && ay >= az)
			face = bpuv_pkg::FACE_PY;
		else if (ny && ax <= ay && az <= ay)
			face = bpuv_pkg::FACE_NY;
		else if (!nz && az >= ax && az >= ay)
			face = bpuv_pkg::FACE_PZ;
		else
			face = bpuv_pkg::FACE_NZ;
	end
endmodule

[rtl/bpuv_lane.sv]
// one axis: bit-serial normalize against the box, then scale to q8.16
module bpuv_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  bpuv_pkg::coord_t                p,
	input  bpuv_pkg::coord_t                lo,
	input  bpuv_pkg::coord_t                hi,
	input  logic [bpuv_pkg::SCALE_BITS-1:0] scale,
	output bpuv_pkg::lane_res_t             res
);
	localparam logic [1:0] LS_IDLE = 2'd0;
	localparam logic [1:0] LS_DIV  = 2'd1;
	localparam logic [1:0] LS_MUL  = 2'd2;

	localparam logic [1:0] MODE_ZERO = 2'd0;
	localparam logic [1:0] MODE_LOW  = 2'd1;
	localparam logic [1:0] MODE_HIGH = 2'd2;
	localparam logic [1:0] MODE_DIV  = 2'd3;

	localparam int CB = bpuv_pkg::COORD_BITS;
	localparam int RB = bpuv_pkg::RATIO_BITS;

	logic [1:0]                      state_q;
	logic [1:0]                      mode_q;
	logic [1:0]                      mode_d;
	logic [bpuv_pkg::CNT_BITS-1:0]   cnt_q;
	logic [CB-1:0]                   rem_q;
	logic [CB-1:0]                   den_q;
	logic [RB-1:0]                   quo_q;
	logic [bpuv_pkg::SCALE_BITS-1:0] scale_q;
	logic                            done_q;
	logic                            zero_q;
	logic [bpuv_pkg::UV_BITS-1:0]    coord_q;

	logic signed [CB:0]                span;
	logic signed [CB:0]                offs;
	logic [CB:0]                       shl;
	logic [CB:0]                       diff;
	logic                              qbit;
	logic [RB:0]                       ratio;
	logic [bpuv_pkg::MUL_BITS-1:0]     prod;
	logic [bpuv_pkg::SHIFT_BITS-1:0]   shifted;

	// span and offset one bit wider so any pair of positions fits
	assign span = $signed({hi[CB-1], hi}) - $signed({lo[CB-1], lo});
	assign offs = $signed({p[CB-1], p}) - $signed({lo[CB-1], lo});

	// case split taken at start
	always_comb begin
		if (hi <= lo)
			mode_d = MODE_ZERO;
		else if (p <= lo)
			mode_d = MODE_LOW;
		else if (p >= hi)
			mode_d = MODE_HIGH;
		else
			mode_d = MODE_DIV;
	end

	// one restoring step: remainder stays below the divisor
	assign shl  = {rem_q, 1'b0};
	assign diff = shl - {1'b0, den_q};
	assign qbit = shl >= {1'b0, den_q};

	// ratio in q1.RATIO_BITS (up to the exact one), then scale and drop to q8.16
	always_comb begin
		case (mode_q)
			MODE_ZERO: ratio = '0;
			MODE_LOW:  ratio = '0;
			MODE_HIGH: ratio = (RB+1)'(1) << RB;
			MODE_DIV:  ratio = {1'b0, quo_q};
			default:   ratio = '0;
		endcase
	end
	assign prod    = bpuv_pkg::MUL_BITS'(ratio) * bpuv_pkg::MUL_BITS'(scale_q);
	assign shifted = prod[bpuv_pkg::MUL_BITS-1:RB-8];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				LS_IDLE: begin
					if (start) begin
						state_q <= LS_DIV;
						cnt_q   <= bpuv_pkg::CNT_BITS'(RB);
						done_q  <= 1'b0;
					end
				end
				LS_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == bpuv_pkg::CNT_BITS'(1))
						state_q <= LS_MUL;
				end
				LS_MUL: begin
					state_q <= LS_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= LS_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == LS_IDLE && start) begin
			mode_q  <= mode_d;
			rem_q   <= offs[CB-1:0];
			den_q   <= span[CB-1:0];
			scale_q <= scale;
			quo_q   <= '0;
		end else if (state_q == LS_DIV) begin
			rem_q <= qbit ? diff[CB-1:0] : shl[CB-1:0];
			quo_q <= {quo_q[RB-2:0], qbit};
		end else if (state_q == LS_MUL) begin
			zero_q  <= mode_q == MODE_ZERO;
			coord_q <= (|shifted[bpuv_pkg::SHIFT_BITS-1:bpuv_pkg::UV_BITS])
				? '1 : shifted[bpuv_pkg::UV_BITS-1:0];
		end
	end

	assign res.done  = done_q;
	assign res.zero  = zero_q;
	assign res.coord = coord_q;
endmodule

[sim/box_projection_uv_checker.sv]
`timescale 1ns / 100ps
// checker that predicts uv words from observed vertex words and compares them
module box_projection_uv_checker
	import bpuv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_BITS-1:0]   cfg_index,
	input  logic [SCALE_BITS-1:0] cfg_wdata,
	bpuv_in_if                    vtx,
	bpuv_out_if                   uv,
	output int                    uv_pending,
	output int                    mismatch_count
);

	typedef struct packed {
		logic [UV_BITS-1:0]   tex_u;
		logic [UV_BITS-1:0]   tex_v;
		logic [FACE_BITS-1:0] face;
		logic [STAT_BITS-1:0] status;
	} uv_word_t;

	localparam longint RATIO_ONE = longint'(1) << RATIO_BITS;
	localparam longint UV_SAT    = (longint'(1) << UV_BITS) - 1;

	uv_word_t              uv_expect_q[$];
	uv_word_t              predicted;
	uv_word_t              observed;
	logic [SCALE_BITS-1:0] scale_x, scale_y, scale_z;
	coord_t                lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic                  box_empty;
	logic                  zero_span;
	int                    fail_tally;

	// cube face from sign and magnitude compares, ties go to the earlier face
	function automatic logic [FACE_BITS-1:0] pick_face(nrm_t nx, nrm_t ny, nrm_t nz);
		longint x, y, z, ax, ay, az;
		x  = nx;
		y  = ny;
		z  = nz;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		if (x >= ay && x >= az) return FACE_PX;
		if (x < 0 && ay <= ax && az <= ax) return FACE_NX;
		if (y >= ax && y >= az) return FACE_PY;
		if (y < 0 && ax <= ay && az <= ay) return FACE_NY;
		if (z >= ax && z >= ay) return FACE_PZ;
		return FACE_NZ;
	endfunction

	// (p - lo) / (hi - lo) clamped to 0..1, times the axis scale, as q8.16
	function automatic logic [UV_BITS-1:0] norm_scale(coord_t p, coord_t lo, coord_t hi,
			logic [SCALE_BITS-1:0] scale, inout logic span_zero);
		longint ratio, prod;
		if (hi <= lo) begin
			span_zero = 1'b1;
			return '0;
		end
		if (p <= lo)
			ratio = 0;
		else if (p >= hi)
			ratio = RATIO_ONE;
		else begin
			ratio = ((longint'(p) - longint'(lo)) << RATIO_BITS) / (longint'(hi) - longint'(lo));
			if (ratio > RATIO_ONE)
				ratio = RATIO_ONE;
		end
		prod = (ratio * longint'(scale)) >> (RATIO_BITS - 8);
		if (prod > UV_SAT)
			prod = UV_SAT;
		return prod[UV_BITS-1:0];
	endfunction

	task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", field, want, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x        = SCALE_RESET;
			scale_y        = SCALE_RESET;
			scale_z        = SCALE_RESET;
			{lo_x, lo_y, lo_z, hi_x, hi_y, hi_z} = '0;
			box_empty      = 1'b1;
			fail_tally     = 0;
			uv_expect_q.delete();
			uv_pending     <= 0;
			mismatch_count <= 0;
		end else begin
			// scale register writes, other indexes change nothing
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE_X: scale_x = cfg_wdata;
					REG_SCALE_Y: scale_y = cfg_wdata;
					REG_SCALE_Z: scale_z = cfg_wdata;
					default: ;
				endcase
			end

			// vertex word taken
			if (vtx.valid && vtx.ready) begin
				case (vtx.command)
					CMD_CLEAR: begin
						{lo_x, lo_y, lo_z, hi_x, hi_y, hi_z} = '0;
						box_empty = 1'b1;
					end
					CMD_ADD: begin
						if (box_empty) begin
							lo_x = vtx.pos_x;
							lo_y = vtx.pos_y;
							lo_z = vtx.pos_z;
							hi_x = vtx.pos_x;
							hi_y = vtx.pos_y;
							hi_z = vtx.pos_z;
							box_empty = 1'b0;
						end else begin
							if (vtx.pos_x < lo_x) lo_x = vtx.pos_x;
							if (vtx.pos_y < lo_y) lo_y = vtx.pos_y;
							if (vtx.pos_z < lo_z) lo_z = vtx.pos_z;
							if (vtx.pos_x > hi_x) hi_x = vtx.pos_x;
							if (vtx.pos_y > hi_y) hi_y = vtx.pos_y;
							if (vtx.pos_z > hi_z) hi_z = vtx.pos_z;
						end
					end
					CMD_PROJECT: begin
						predicted.face  = pick_face(vtx.nrm_x, vtx.nrm_y, vtx.nrm_z);
						predicted.tex_u = '0;
						predicted.tex_v = '0;
						zero_span       = 1'b0;
						if (box_empty) begin
							predicted.status = STAT_EMPTY;
						end else begin
							// the two axes lying in the face plane
							case (predicted.face)
								FACE_PX, FACE_NX: begin
									predicted.tex_u = norm_scale(vtx.pos_y, lo_y, hi_y, scale_y, zero_span);
									predicted.tex_v = norm_scale(vtx.pos_z, lo_z, hi_z, scale_z, zero_span);
								end
								FACE_PY, FACE_NY: begin
									predicted.tex_u = norm_scale(vtx.pos_x, lo_x, hi_x, scale_x, zero_span);
									predicted.tex_v = norm_scale(vtx.pos_z, lo_z, hi_z, scale_z, zero_span);
								end
								default: begin
									predicted.tex_u = norm_scale(vtx.pos_x, lo_x, hi_x, scale_x, zero_span);
									predicted.tex_v = norm_scale(vtx.pos_y, lo_y, hi_y, scale_y, zero_span);
								end
							endcase
							predicted.status = zero_span ? STAT_ZERO : STAT_OK;
						end
						uv_expect_q.push_back(predicted);
					end
					default: ;
				endcase
			end

			// uv word taken
			if (uv.valid && uv.ready) begin
				observed = '{tex_u: uv.tex_u, tex_v: uv.tex_v, face: uv.face, status: uv.status};
				if (uv_expect_q.size() == 0) begin
					$error("uv word with nothing predicted: tex_u %0d tex_v %0d face %0d status %0d",
						observed.tex_u, observed.tex_v, observed.face, observed.status);
					fail_tally++;
				end else begin
					predicted = uv_expect_q.pop_front();
					check_field("tex_u", predicted.tex_u, observed.tex_u);
					check_field("tex_v", predicted.tex_v, observed.tex_v);
					check_field("face", predicted.face, observed.face);
					check_field("status", predicted.status, observed.status);
				end
			end

			uv_pending     <= uv_expect_q.size();
			mismatch_count <= fail_tally;
		end
	end

endmodule

[sim/box_projection_uv_generator_tb.sv]
`timescale 1ns / 100ps
// testbench top: clock, reset, vertex stimulus and verdict for the box projection uv generator
module box_projection_uv_generator_tb;
	import bpuv_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int SETTLE       = 2 * (RATIO_BITS + 4) + 10;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASE_WORDS  = 150;

	// register index with no register behind it
	localparam logic [REG_BITS-1:0] REG_UNUSED = 2'd3;
	// command code the block ignores
	localparam logic [CMD_BITS-1:0] CMD_NONE   = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [REG_BITS-1:0]   cfg_index;
	logic [SCALE_BITS-1:0] cfg_wdata;
	logic                  steady;
	int                    uv_pending;
	int                    mismatch_count;
	int                    words_sent;
	int                    quiet_cycles;

	bpuv_in_if  vtx ();
	bpuv_out_if uv ();

	box_projection_uv_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.vtx       (vtx),
		.uv        (uv)
	);

	box_projection_uv_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.vtx            (vtx),
		.uv             (uv),
		.uv_pending     (uv_pending),
		.mismatch_count (mismatch_count)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// uv receiver stalls at random unless held steady
	always @(posedge clk) begin
		if (arst_n)
			uv.ready <= steady || ($urandom_range(99) >= 16);
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((vtx.valid && vtx.ready) || (uv.valid && uv.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic coord_t pick_coord();
		int unsigned mode;
		mode = $urandom_range(99);
		if (mode < 50)
			return coord_t'($urandom);
		if (mode < 85)
			return coord_t'(int'($urandom_range(128)) - 64);
		case ($urandom_range(2))
			0:       return coord_t'(-32768);
			1:       return coord_t'(32767);
			default: return coord_t'(0);
		endcase
	endfunction

	function automatic nrm_t pick_nrm();
		if ($urandom_range(99) < 60)
			return nrm_t'($urandom);
		return nrm_t'(int'($urandom_range(6)) - 3);
	endfunction

	// offer one vertex word, with a random gap in front, and wait for it to be taken
	task automatic send_word(input logic [CMD_BITS-1:0] cmd, input coord_t px, py, pz,
			input nrm_t nx, ny, nz);
		while (!steady && $urandom_range(99) < 16) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
		end
		vtx.valid   <= 1'b1;
		vtx.command <= cmd;
		vtx.pos_x   <= px;
		vtx.pos_y   <= py;
		vtx.pos_z   <= pz;
		vtx.nrm_x   <= nx;
		vtx.nrm_y   <= ny;
		vtx.nrm_z   <= nz;
		@(posedge clk);
		while (!vtx.ready)
			@(posedge clk);
		if (cmd != CMD_NONE)
			words_sent++;
	endtask

	task automatic send_random(input logic [CMD_BITS-1:0] cmd);
		send_word(cmd, pick_coord(), pick_coord(), pick_coord(), pick_nrm(), pick_nrm(), pick_nrm());
	endtask

	// hold the sender until every uv word is back and the block has gone quiet
	task automatic drain();
		vtx.valid <= 1'b0;
		@(posedge clk);
		while (uv_pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_scales(input logic [SCALE_BITS-1:0] sx, sy, sz);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SCALE_X;
		cfg_wdata <= sx;
		@(posedge clk);
		cfg_index <= REG_SCALE_Y;
		cfg_wdata <= sy;
		@(posedge clk);
		cfg_index <= REG_SCALE_Z;
		cfg_wdata <= sz;
		@(posedge clk);
		// unused index must leave the scales alone
		cfg_index <= REG_UNUSED;
		cfg_wdata <= SCALE_BITS'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly clear, a few adds, then projects; the rest loose words of any command
	task automatic random_words(input int count);
		int stop;
		int n;
		stop = words_sent + count;
		while (words_sent < stop) begin
			if ($urandom_range(99) < 80) begin
				send_random(CMD_CLEAR);
				n = $urandom_range(1, 6);
				repeat (n) send_random(CMD_ADD);
				n = $urandom_range(2, 10);
				repeat (n) send_random(CMD_PROJECT);
			end else
				send_random(CMD_BITS'($urandom));
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_SCALE_X;
		cfg_wdata   = '0;
		steady      = 1'b0;
		words_sent  = 0;
		vtx.valid   = 1'b0;
		vtx.command = CMD_CLEAR;
		vtx.pos_x   = '0;
		vtx.pos_y   = '0;
		vtx.pos_z   = '0;
		vtx.nrm_x   = '0;
		vtx.nrm_y   = '0;
		vtx.nrm_z   = '0;
		uv.ready    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// project before any add, zero normal goes to +x
		send_word(CMD_PROJECT, 100, -100, 5, 0, 0, 0);
		send_word(CMD_PROJECT, 0, 0, 0, 0, -32768, 0);
		// ignored command
		send_word(CMD_NONE, 1, 2, 3, 1, 1, 1);
		// single point box, every span zero
		send_word(CMD_ADD, 0, 0, 0, 0, 0, 0);
		send_word(CMD_PROJECT, 0, 0, 0, 1, 0, 0);
		// full range box, one normal per face and the ties
		send_word(CMD_ADD, -32768, -32768, -32768, 0, 0, 0);
		send_word(CMD_ADD, 32767, 32767, 32767, 0, 0, 0);
		send_word(CMD_PROJECT, -32768, -32768, -32768, -5, 3, -5);
		send_word(CMD_PROJECT, 32767, 32767, 32767, 0, 7, 7);
		send_word(CMD_PROJECT, 1234, -4321, 0, 0, 0, 9);
		send_word(CMD_PROJECT, 1234, -4321, 0, 0, 0, -9);
		send_word(CMD_PROJECT, -1, 1, 16384, 32767, -32768, 0);
		send_word(CMD_PROJECT, 7, -7, 77, -32768, -32768, -32768);
		send_word(CMD_PROJECT, 300, 200, 100, 4, -4, 4);
		// clear empties the box again
		send_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send_word(CMD_PROJECT, 5, 5, 5, 0, 0, 1);
		// narrow box with a zero y span, positions inside and outside
		send_word(CMD_ADD, 10, -5, 100, 0, 0, 0);
		send_word(CMD_ADD, 20, -5, 300, 0, 0, 0);
		send_word(CMD_PROJECT, 15, -5, 200, 1, 0, 0);
		send_word(CMD_PROJECT, 15, -5, 200, 0, 0, 1);
		send_word(CMD_PROJECT, 15, -5, 200, 0, -3, 0);
		send_word(CMD_PROJECT, 0, -5, 1000, 0, -1, 0);
		send_word(CMD_PROJECT, 25, 9, 50, 0, -1, 0);

		// random words under several scale settings
		drain();
		write_scales(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_words(PHASE_WORDS);

		drain();
		steady <= 1'b1;
		write_scales(16'h0000, 16'h0000, 16'h0000);
		random_words(PHASE_WORDS);

		drain();
		steady <= 1'b0;
		write_scales(SCALE_BITS'($urandom), SCALE_BITS'($urandom), SCALE_BITS'($urandom));
		random_words(PHASE_WORDS);

		drain();
		write_scales(16'h0000, 16'hFFFF, 16'h0001);
		random_words(PHASE_WORDS);

		drain();
		write_scales(SCALE_RESET, SCALE_RESET, SCALE_RESET);
		random_words(PHASE_WORDS);

		drain();
		if (mismatch_count == 0 && uv_pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
